/* rtl/core/ffha_pkg.sv */
// Shared types, constants and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned SEGMENTS = 64;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned IDX_W    = $clog2(SEGMENTS);
  localparam int unsigned CNT_W    = $clog2(SEGMENTS + 1);
  localparam int unsigned LIVE_W   = 7;
  localparam int unsigned MAXL_W   = 6;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIVE   = 1'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd4;

  localparam logic [OFF_W-1:0] HEAP_RESET = 16'd2000;
  localparam logic [MAXL_W-1:0] MAX_LIVE_RESET = 6'd32;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] size;
    logic             occ;
  } seg_t;

  typedef struct packed {
    logic             opcode;
    logic [15:0]      req_size;
    logic [15:0]      block_addr;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [15:0]       granted_addr;
    logic [LIVE_W-1:0] live_count;
  } out_t;

  typedef enum logic [1:0] {
    WR_COPY,
    WR_SPLIT,
    WR_TAKE,
    WR_MERGE
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_SUB
  } cnt_op_e;

  typedef enum logic [1:0] {
    LIVE_HOLD,
    LIVE_INC,
    LIVE_DEC
  } live_op_e;

  typedef struct packed {
    logic              req_load;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    wr_sel_e           wr_sel;
    logic              hit_load;
    logic              prev_load;
    logic              right_load;
    cnt_op_e           cnt_op;
    logic [1:0]        cnt_sub;
    live_op_e          live_op;
    logic              out_load;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    in_t               req;
    seg_t              rd;
    logic [CNT_W-1:0]  count;
    logic [LIVE_W-1:0] live;
    logic [MAXL_W-1:0] max_live;
    logic              left;
    logic              right;
    logic              out_free;
  } stat_t;

endpackage

/* rtl/core/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with coalescing.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o  in_data_i (opcode, req_size, block_addr)
//   out      output     out_valid_o/out_stall_i out_data_o (status, granted_addr, live_count)
//   cfg      input      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One request is handled at a time. The controller scans the table entry by entry and
// moves each shifted entry with one read and one write, then loads the result and returns
// to idle before the next request is taken. The segment table has one read and one write
// port and registered read data. After reset the table needs no clearing pass: entry 0
// reads as the whole heap until it is first written. A new request is taken while a result
// waits in the output register; a stalled output only holds the block at the end of the
// next request.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  cmd_t  cmd;
  stat_t stat;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

/* rtl/core/ffha_dp.sv */
// Datapath of the heap allocator: segment table, counters, captured entries, result register.
module ffha_dp import ffha_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_t                  in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_t                 out_data_o,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o
);

  seg_t mem [SEGMENTS];

  seg_t              rd_q, hit_q, prev_q, right_q, wr_data;
  in_t               req_q;
  logic [OFF_W-1:0]  heap_q;
  logic [MAXL_W-1:0] max_live_q;
  logic [CNT_W-1:0]  count_q;
  logic [LIVE_W-1:0] live_q;
  logic              fresh_q, prev_vld_q, right_vld_q, out_valid_q;
  out_t              out_q;
  logic              left, right;
  logic [OFF_W-1:0]  merge_size;
  seg_t              init_seg;

  assign left  = prev_vld_q && !prev_q.occ;
  assign right = right_vld_q && !right_q.occ;
  assign merge_size = (left ? prev_q.size : '0) + hit_q.size + (right ? right_q.size : '0);
  assign init_seg = '{start: '0, size: heap_q, occ: 1'b0};

  always_comb begin
    case (cmd_i.wr_sel)
      WR_COPY:  wr_data = rd_q;
      WR_SPLIT: wr_data = '{start: hit_q.start + req_q.req_size,
                            size:  hit_q.size - req_q.req_size, occ: 1'b0};
      WR_TAKE:  wr_data = '{start: hit_q.start, size: req_q.req_size, occ: 1'b1};
      WR_MERGE: wr_data = '{start: left ? prev_q.start : hit_q.start,
                            size:  merge_size, occ: 1'b0};
      default:  wr_data = rd_q;
    endcase
  end

  // Table memory: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr];
    end
  end

  // Payload captures.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.hit_load) begin
      hit_q <= stat_o.rd;
    end
    if (cmd_i.prev_load) begin
      prev_q <= stat_o.rd;
    end
    if (cmd_i.right_load) begin
      right_q <= stat_o.rd;
    end
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.res_status;
      out_q.granted_addr <= (cmd_i.res_status == ST_OK && req_q.opcode == OP_ALLOC) ?
                            hit_q.start : '0;
      out_q.live_count   <= live_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= HEAP_RESET;
      max_live_q  <= MAX_LIVE_RESET;
      count_q     <= CNT_W'(1);
      live_q      <= '0;
      fresh_q     <= 1'b1;
      prev_vld_q  <= 1'b0;
      right_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.req_load) begin
        prev_vld_q  <= 1'b0;
        right_vld_q <= 1'b0;
      end
      if (cmd_i.prev_load) begin
        prev_vld_q <= 1'b1;
      end
      if (cmd_i.right_load) begin
        right_vld_q <= 1'b1;
      end
      // Entry 0 is served from the heap size register until it is first written.
      if (cmd_i.wr_en && cmd_i.wr_addr == '0) begin
        fresh_q <= 1'b0;
      end
      case (cmd_i.cnt_op)
        CNT_INC: count_q <= count_q + CNT_W'(1);
        CNT_SUB: count_q <= count_q - CNT_W'(cmd_i.cnt_sub);
        default: count_q <= count_q;
      endcase
      case (cmd_i.live_op)
        LIVE_INC: live_q <= live_q + LIVE_W'(1);
        LIVE_DEC: if (live_q != '0) begin
          live_q <= live_q - LIVE_W'(1);
        end
        default:  live_q <= live_q;
      endcase
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BYTES) begin
          heap_q  <= cfg_wdata_i[OFF_W-1:0];
          count_q <= CNT_W'(1);
          live_q  <= '0;
          fresh_q <= 1'b1;
        end else if (cfg_idx_i == CFG_MAX_LIVE) begin
          max_live_q <= cfg_wdata_i[MAXL_W-1:0];
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic rd_fresh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_fresh_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      rd_fresh_q <= fresh_q && cmd_i.rd_addr == '0;
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.rd       = rd_fresh_q ? init_seg : rd_q;
  assign stat_o.count    = count_q;
  assign stat_o.live     = live_q;
  assign stat_o.max_live = max_live_q;
  assign stat_o.left     = left;
  assign stat_o.right    = right;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/ffha_ctrl.sv */
// Controller of the heap allocator: sequences scans, table shifts and result loading.
module ffha_ctrl import ffha_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_F_RCAP,
    S_F_MERGE,
    S_RM_RD,
    S_RM_WR,
    S_SH_RD,
    S_SH_WR,
    S_A_SPLIT,
    S_A_TAKE,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d, j_q, j_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [1:0]        d_q, d_d;
  logic [STAT_W-1:0] res_q, res_d;

  logic             is_alloc;
  logic [CNT_W:0]   jd_sum;
  logic [CNT_W-1:0] k_plus1;

  assign is_alloc = stat_i.req.opcode == OP_ALLOC;
  assign jd_sum   = {1'b0, j_q} + (CNT_W + 1)'(d_q);
  assign k_plus1  = CNT_W'(k_q) + CNT_W'(1);
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    idx_d   = idx_q;
    j_d     = j_q;
    k_d     = k_q;
    d_d     = d_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_d = '0;
        if (is_alloc && stat_i.live >= LIVE_W'(stat_i.max_live)) begin
          res_d   = ST_LIMIT;
          state_d = S_FIN;
        end else if (is_alloc && stat_i.req.req_size == '0) begin
          res_d   = ST_ZERO;
          state_d = S_FIN;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q == stat_i.count) begin
          res_d   = is_alloc ? ST_NOFIT : ST_NOTFOUND;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q[IDX_W-1:0];
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        k_d = idx_q[IDX_W-1:0];
        if (is_alloc) begin
          if (!stat_i.rd.occ && stat_i.rd.size >= stat_i.req.req_size) begin
            cmd_o.hit_load = 1'b1;
            if (stat_i.rd.size > stat_i.req.req_size) begin
              if (stat_i.count == CNT_W'(SEGMENTS)) begin
                res_d   = ST_NOFIT;
                state_d = S_FIN;
              end else begin
                j_d     = stat_i.count;
                state_d = S_SH_RD;
              end
            end else begin
              state_d = S_A_TAKE;
            end
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          if (stat_i.rd.occ && stat_i.rd.start == stat_i.req.block_addr) begin
            cmd_o.hit_load = 1'b1;
            if (idx_q + CNT_W'(1) < stat_i.count) begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = IDX_W'(idx_q + CNT_W'(1));
              state_d = S_F_RCAP;
            end else begin
              state_d = S_F_MERGE;
            end
          end else begin
            cmd_o.prev_load = 1'b1;
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_F_RCAP: begin
        cmd_o.right_load = 1'b1;
        state_d = S_F_MERGE;
      end
      S_F_MERGE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_MERGE;
        cmd_o.wr_addr = stat_i.left ? k_q - IDX_W'(1) : k_q;
        cmd_o.live_op = LIVE_DEC;
        // Entries after the merged one close up by the number of absorbed neighbours.
        j_d = stat_i.left ? CNT_W'(k_q) : k_plus1;
        d_d = {1'b0, stat_i.left} + {1'b0, stat_i.right};
        if (!stat_i.left && !stat_i.right) begin
          res_d   = ST_OK;
          state_d = S_FIN;
        end else begin
          state_d = S_RM_RD;
        end
      end
      S_RM_RD: begin
        if (jd_sum >= {1'b0, stat_i.count}) begin
          cmd_o.cnt_op  = CNT_SUB;
          cmd_o.cnt_sub = d_q;
          res_d   = ST_OK;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = jd_sum[IDX_W-1:0];
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.wr_addr = j_q[IDX_W-1:0];
        j_d     = j_q + CNT_W'(1);
        state_d = S_RM_RD;
      end
      S_SH_RD: begin
        if (j_q <= k_plus1) begin
          state_d = S_A_SPLIT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = IDX_W'(j_q - CNT_W'(1));
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.wr_addr = j_q[IDX_W-1:0];
        j_d     = j_q - CNT_W'(1);
        state_d = S_SH_RD;
      end
      S_A_SPLIT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SPLIT;
        cmd_o.wr_addr = k_q + IDX_W'(1);
        cmd_o.cnt_op  = CNT_INC;
        state_d = S_A_TAKE;
      end
      S_A_TAKE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_TAKE;
        cmd_o.wr_addr = k_q;
        cmd_o.live_op = LIVE_INC;
        res_d   = ST_OK;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.res_status = res_q;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
      d_q     <= '0;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      k_q     <= k_d;
      d_q     <= d_d;
      res_q   <= res_d;
    end
  end

endmodule
